>>> src/assert_macros.svh
// Assertion macros shared by the priority queue RTL.
// Each use expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define PQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Checks that a condition leads to a consequence in the next cycle.
`define PQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/pq_pkg.sv
// Shared types, constants and helpers of the stable minimum priority queue.
// Used by pq_cell and min_priority_queue_fifo_ties_unit; depends on nothing.
package pq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_DELETE = 1'b1
   } pq_func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } pq_status_type;

   typedef struct packed {
      pq_func_type        func;
      logic signed [31:0] item_value;
      logic [7:0]         item_priority;
   } pq_req_type;

   typedef struct packed {
      logic               removed_valid;
      logic signed [31:0] removed_value;
      logic [7:0]         removed_priority;
      pq_status_type      status;
   } pq_rsp_type;

   typedef logic [PRIORITY_BITS-1:0] pq_prio_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] value;
      pq_prio_type        prio;
   } pq_slot_type;

   typedef struct packed {
      logic        ins;
      logic        del;
      logic [31:0] value;
      pq_prio_type prio;
   } pq_cmd_type;

   function automatic pq_prio_type to_slot_prio(input logic [7:0] p);
      logic [31:0] wide;
      wide = {24'd0, p};
      return wide[PRIORITY_BITS-1:0];
   endfunction

   function automatic logic [7:0] to_field_prio(input pq_prio_type p);
      logic [31:0] wide;
      wide = 32'(p);
      return wide[7:0];
   endfunction

endpackage

>>> src/min_priority_queue_fifo_ties_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  pq_req_type
// rsp       out        rsp_valid/rsp_stall  pq_rsp_type
// One item is taken per cycle while req_stall is low; its result appears in the output register in the next cycle.
// Every cell of the chain compares and moves in parallel, so one cell sets the cycle.
// Reset is synchronous and empties the chain and the output register.
// req_stall is high only while the output register holds a result and rsp_stall is high.
// The chain keeps entries sorted by priority with earlier arrivals ahead on ties.
module min_priority_queue_fifo_ties_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pq_pkg::pq_req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pq_pkg::pq_rsp_type rsp_data
);

`include "assert_macros.svh"

   pq_pkg::pq_slot_type              chain [pq_pkg::CAPACITY];
   logic [pq_pkg::CAPACITY-1:0]      gt_vec;
   logic [pq_pkg::CAPACITY-1:0]      valid_vec;
   pq_pkg::pq_cmd_type               cmd;
   logic                             accept;
   logic                             is_insert;
   logic                             full;
   logic                             empty;
   pq_pkg::pq_rsp_type               rsp_in;
   pq_pkg::pq_rsp_type               rsp_ff;
   logic                             rsp_valid_in;
   logic                             rsp_valid_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_insert = (req_data.func == pq_pkg::FUNC_INSERT);
   assign full      = chain[pq_pkg::CAPACITY-1].valid;
   assign empty     = !chain[0].valid;

   assign cmd.ins   = accept && is_insert && !full;
   assign cmd.del   = accept && !is_insert && !empty;
   assign cmd.value = req_data.item_value;
   assign cmd.prio  = pq_pkg::to_slot_prio(req_data.item_priority);

   for (genvar i = 0; i < pq_pkg::CAPACITY; i++) begin : g_cell
      pq_pkg::pq_slot_type left_slot;
      pq_pkg::pq_slot_type right_slot;
      logic                left_gt;

      if (i == 0) begin : g_first
         assign left_slot = '0;
         assign left_gt   = 1'b0;
      end else begin : g_mid
         assign left_slot = chain[i-1];
         assign left_gt   = gt_vec[i-1];
      end

      if (i == pq_pkg::CAPACITY - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_inner
         assign right_slot = chain[i+1];
      end

      assign valid_vec[i] = chain[i].valid;

      pq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_slot  (left_slot),
         .left_gt    (left_gt),
         .right_slot (right_slot),
         .slot       (chain[i]),
         .gt         (gt_vec[i])
      );
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = pq_pkg::STATUS_DONE;
      if (is_insert) begin
         if (full) begin
            rsp_in.status = pq_pkg::STATUS_FULL;
         end
      end else if (empty) begin
         rsp_in.status = pq_pkg::STATUS_EMPTY;
      end else begin
         rsp_in.removed_valid    = 1'b1;
         rsp_in.removed_value    = chain[0].value;
         rsp_in.removed_priority = pq_pkg::to_field_prio(chain[0].prio);
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Occupied cells always form an unbroken run starting at the head.
   `PQ_ASSERT(a_chain_packed, clock, reset,
      (valid_vec & (valid_vec + {{(pq_pkg::CAPACITY-1){1'b0}}, 1'b1})) == '0)
   // The head never holds a larger priority than the cell behind it.
   `PQ_ASSERT(a_head_sorted, clock, reset,
      !chain[1].valid || (chain[0].prio <= chain[1].prio))
   // A delete on a non-empty queue returns an entry in the next cycle.
   `PQ_ASSERT_NEXT(a_delete_returns, clock, reset, cmd.del,
      rsp_valid && rsp_data.removed_valid)
   // A dropped insert leaves the chain occupancy unchanged.
   `PQ_ASSERT_NEXT(a_full_drop, clock, reset, accept && is_insert && full,
      $stable(valid_vec))

endmodule

>>> src/pq_cell.sv
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
// Depends on pq_pkg for the slot and command types.
module pq_cell (
   input  logic                clock,
   input  logic                reset,
   input  pq_pkg::pq_cmd_type  cmd,
   input  pq_pkg::pq_slot_type left_slot,
   input  logic                left_gt,
   input  pq_pkg::pq_slot_type right_slot,
   output pq_pkg::pq_slot_type slot,
   output logic                gt
);

   logic               valid_ff;
   logic               valid_in;
   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   pq_pkg::pq_prio_type prio_ff;
   pq_pkg::pq_prio_type prio_in;

   // An empty cell counts as holding a priority above every real one.
   assign gt = !valid_ff || (prio_ff > cmd.prio);

   assign slot.valid = valid_ff;
   assign slot.value = value_ff;
   assign slot.prio  = prio_ff;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      if (cmd.ins && gt) begin
         if (left_gt) begin
            valid_in = left_slot.valid;
            value_in = left_slot.value;
            prio_in  = left_slot.prio;
         end else begin
            valid_in = 1'b1;
            value_in = cmd.value;
            prio_in  = cmd.prio;
         end
      end else if (cmd.del) begin
         valid_in = right_slot.valid;
         value_in = right_slot.value;
         prio_in  = right_slot.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

endmodule

>>> bench/tb_min_priority_queue_fifo_ties_unit.sv
// Self-checking bench for the stable minimum priority queue unit.
// Drives insert and delete items with random gaps and stalls, and checks each result
// against a queue kept in arrival order. Depends on pq_pkg and the unit itself.
module tb_min_priority_queue_fifo_ties_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1900;
   localparam int SEGMENT_LEN  = 40;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic signed [31:0]  value;
      pq_pkg::pq_prio_type prio;
   } held_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   pq_pkg::pq_req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   pq_pkg::pq_rsp_type rsp_data;

   pq_pkg::pq_req_type request_q[$];
   pq_pkg::pq_rsp_type outcome_q[$];
   held_entry_type     held[$];

   int total_items = 0;
   int accepted_count = 0;
   int result_count = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int drv_gap = 0;
   int mon_left = 0;
   bit drv_calm = 1'b0;
   bit mon_calm = 1'b0;

   min_priority_queue_fifo_ties_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic pq_pkg::pq_req_type make_req(input pq_pkg::pq_func_type f,
                                                   input logic [31:0] v,
                                                   input logic [7:0] p);
      pq_pkg::pq_req_type r;
      r.func          = f;
      r.item_value    = v;
      r.item_priority = p;
      return r;
   endfunction

   function automatic pq_pkg::pq_rsp_type serve_request(input pq_pkg::pq_req_type r);
      pq_pkg::pq_rsp_type o;
      int                 best;
      o = '0;
      o.status = pq_pkg::STATUS_DONE;
      if (r.func == pq_pkg::FUNC_INSERT) begin
         if (held.size() >= pq_pkg::CAPACITY) begin
            o.status = pq_pkg::STATUS_FULL;
         end else begin
            held.push_back('{value: r.item_value,
                             prio: pq_pkg::pq_prio_type'(r.item_priority)});
         end
      end else if (held.size() == 0) begin
         o.status = pq_pkg::STATUS_EMPTY;
      end else begin
         best = 0;
         for (int i = 1; i < held.size(); i++) begin
            if (held[i].prio < held[best].prio) begin
               best = i;
            end
         end
         o.removed_valid    = 1'b1;
         o.removed_value    = held[best].value;
         o.removed_priority = 8'(held[best].prio);
         held.delete(best);
      end
      return o;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(15, 30);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatches < 100) begin
         $display("result %0d: %s expected %0h got %0h", result_count, field, want, got);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap <= 0;
      end else begin
         drv_calm <= ($urandom_range(0, 249) == 0) ? !drv_calm : drv_calm;
         if (!(req_valid && req_stall)) begin
            if (req_valid) begin
               outcome_q.push_back(serve_request(req_data));
               accepted_count++;
            end
            if (drv_gap > 0) begin
               req_valid <= 1'b0;
               drv_gap <= drv_gap - 1;
            end else if (request_q.size() > 0) begin
               req_data <= request_q.pop_front();
               req_valid <= 1'b1;
               drv_gap <= pick_gap(drv_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      pq_pkg::pq_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         mon_left <= 0;
      end else begin
         mon_calm <= ($urandom_range(0, 249) == 0) ? !mon_calm : mon_calm;
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("result with nothing pending, status", '0,
                               32'(rsp_data.status));
            end else begin
               want = outcome_q.pop_front();
               if (rsp_data.removed_valid !== want.removed_valid) begin
                  report_mismatch("removed_valid", 32'(want.removed_valid),
                                  32'(rsp_data.removed_valid));
               end
               if (rsp_data.removed_value !== want.removed_value) begin
                  report_mismatch("removed_value", want.removed_value, rsp_data.removed_value);
               end
               if (rsp_data.removed_priority !== want.removed_priority) begin
                  report_mismatch("removed_priority", 32'(want.removed_priority),
                                  32'(rsp_data.removed_priority));
               end
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", 32'(want.status), 32'(rsp_data.status));
               end
            end
            result_count++;
         end
         if (mon_left > 0) begin
            rsp_stall <= 1'b1;
            mon_left <= mon_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            mon_left <= pick_gap(mon_calm);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int          insert_pct;
      int          prio_hi;
      logic [31:0] extremes[16];
      logic [7:0]  prios[16];

      extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                   32'd5, 32'd6, 32'd7, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8,
                   32'd9, 32'd10, 32'd11, 32'd12};
      prios = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd7, 8'd7, 8'd7, 8'd128,
                8'd0, 8'd255, 8'd1, 8'd7, 8'd254, 8'd0, 8'd128, 8'd1};

      request_q.push_back(make_req(pq_pkg::FUNC_DELETE, 32'hffff_ffff, 8'hff));
      for (int i = 0; i < 16; i++) begin
         request_q.push_back(make_req(pq_pkg::FUNC_INSERT, extremes[i], prios[i]));
      end
      request_q.push_back(make_req(pq_pkg::FUNC_INSERT, 32'h5a5a_a5a5, 8'd0));
      for (int i = 0; i < 5; i++) begin
         request_q.push_back(make_req(pq_pkg::FUNC_DELETE, $urandom, 8'($urandom)));
      end

      insert_pct = 50;
      prio_hi = 255;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % SEGMENT_LEN == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  insert_pct = 15;
               end
               1: begin
                  insert_pct = 50;
               end
               default: begin
                  insert_pct = 85;
               end
            endcase
            prio_hi = ($urandom_range(0, 1) == 0) ? 3 : 255;
         end
         request_q.push_back(make_req(
            ($urandom_range(0, 99) < insert_pct) ? pq_pkg::FUNC_INSERT : pq_pkg::FUNC_DELETE,
            $urandom, 8'($urandom_range(0, prio_hi))));
      end
      total_items = request_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || outcome_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/pq_pkg.sv
src/pq_cell.sv
src/min_priority_queue_fifo_ties_unit.sv
bench/tb_min_priority_queue_fifo_ties_unit.sv
